// ----- src/cabm_pkg.sv -----
// Package for the cyclical asynchronous buffer manager.
// Holds operation and status codes, register indexes, field widths and the store control struct.
// Depends on nothing; every other file imports it.
`default_nettype none

package cabm_pkg;

	// Field widths fixed by the interface
	localparam int OP_W      = 3;
	localparam int IDX_W     = 4;
	localparam int ST_W      = 2;
	localparam int BCNT_W    = 5;
	localparam int SIZE_W    = 13;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// Default sizing of the pool
	localparam int DEF_NUM_BUFFERS = 16;
	localparam int DEF_COUNT_WIDTH = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
	localparam logic [OP_W-1:0] OP_RESERVE = 3'd1;
	localparam logic [OP_W-1:0] OP_PUT     = 3'd2;
	localparam logic [OP_W-1:0] OP_GET     = 3'd3;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [ST_W-1:0] ST_BADIDX = 2'd2;
	localparam logic [ST_W-1:0] ST_USECNT = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd2;

	// Configuration reset values
	localparam logic [BCNT_W-1:0] RST_BUFFER_COUNT = 5'd16;
	localparam logic [SIZE_W-1:0] RST_MESSAGE_SIZE = 13'd64;
	localparam logic [ADDR_W-1:0] RST_REGION_BASE  = 32'd0;

	// Control from the sequencer to the free stack and reader count store
	typedef struct packed {
		logic rd_en;
		logic cnt_we;
		logic stk_we;
		logic clear;
	} store_ctl_t;

endpackage

`default_nettype wire

// ----- src/cabm_store.sv -----
// Free stack and reader count memories of the buffer manager, with registered reads.
// Per-entry valid bits give the reset contents until an entry is written.
// Depends on cabm_pkg.
`default_nettype none

module cabm_store #(
	parameter int NUM_BUFFERS = cabm_pkg::DEF_NUM_BUFFERS,
	parameter int COUNT_WIDTH = cabm_pkg::DEF_COUNT_WIDTH
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire cabm_pkg::store_ctl_t            ctl,
	input  wire [$clog2(NUM_BUFFERS)-1:0]        cnt_raddr,
	input  wire [$clog2(NUM_BUFFERS)-1:0]        stk_raddr,
	input  wire [$clog2(NUM_BUFFERS)-1:0]        cnt_waddr,
	input  wire [COUNT_WIDTH-1:0]                cnt_wdata,
	input  wire [$clog2(NUM_BUFFERS)-1:0]        stk_waddr,
	input  wire [$clog2(NUM_BUFFERS)-1:0]        stk_wdata,
	output logic [COUNT_WIDTH-1:0]               cnt_rdata,
	output logic [$clog2(NUM_BUFFERS)-1:0]       stk_rdata
);
	import cabm_pkg::*;

	localparam int IW = $clog2(NUM_BUFFERS);

	logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BUFFERS];
	logic [IW-1:0]          stk_mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] cnt_vld_q;
	logic [NUM_BUFFERS-1:0] stk_vld_q;

	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic                   cnt_rv_q;
	logic [IW-1:0]          stk_rd_q;
	logic                   stk_rv_q;
	logic [IW-1:0]          stk_ra_q;

	always_ff @(posedge clk) begin
		if (ctl.cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (ctl.stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (ctl.rd_en) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
			stk_rd_q <= stk_mem[stk_raddr];
			stk_ra_q <= stk_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			stk_vld_q <= '0;
			cnt_rv_q  <= 1'b0;
			stk_rv_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				cnt_vld_q <= '0;
				stk_vld_q <= '0;
			end else begin
				if (ctl.cnt_we) begin
					cnt_vld_q[cnt_waddr] <= 1'b1;
				end
				if (ctl.stk_we) begin
					stk_vld_q[stk_waddr] <= 1'b1;
				end
			end
			if (ctl.rd_en) begin
				cnt_rv_q <= cnt_vld_q[cnt_raddr];
				stk_rv_q <= stk_vld_q[stk_raddr];
			end
		end
	end

	// An unwritten count reads as zero and an unwritten stack slot holds its own position.
	assign cnt_rdata = cnt_rv_q ? cnt_rd_q : '0;
	assign stk_rdata = stk_rv_q ? stk_rd_q : stk_ra_q;

endmodule

`default_nettype wire

// ----- src/cabm_result.sv -----
// Result stage of the buffer manager: registered index times size product, then base add.
// Ends in the output register that drives the result channel.
// Depends on cabm_pkg.
`default_nettype none

module cabm_result #(
	parameter int RW = cabm_pkg::IDX_W
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           start_ready,
	input  wire [RW-1:0]                   res_index,
	input  wire [cabm_pkg::ST_W-1:0]       res_status,
	input  wire                            res_zero,
	input  wire [cabm_pkg::SIZE_W-1:0]     message_size,
	input  wire [cabm_pkg::ADDR_W-1:0]     region_base,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [cabm_pkg::IDX_W-1:0]     result_index,
	output logic [cabm_pkg::ADDR_W-1:0]    message_address,
	output logic [cabm_pkg::ST_W-1:0]      status
);
	import cabm_pkg::*;

	localparam int PW = RW + SIZE_W;

	logic            vld_s1;
	logic [PW-1:0]   prod_s1;
	logic [RW-1:0]   idx_s1;
	logic [ST_W-1:0] st_s1;
	logic            zero_s1;

	logic              out_valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ST_W-1:0]   st_q;

	logic out_free;
	logic adv;
	logic take;

	assign out_free    = !out_valid_q || out_ready;
	assign adv         = vld_s1 && out_free;
	assign start_ready = !vld_s1 || out_free;
	assign take        = start && start_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= PW'(res_index) * PW'(message_size);
			idx_s1  <= res_index;
			st_s1   <= res_status;
			zero_s1 <= res_zero;
		end
		if (adv) begin
			idx_q  <= IDX_W'(idx_s1);
			st_q   <= st_s1;
			addr_q <= zero_s1 ? '0 : region_base + ADDR_W'(prod_s1);
		end
	end

	assign out_valid       = out_valid_q;
	assign result_index    = idx_q;
	assign message_address = addr_q;
	assign status          = st_q;

endmodule

`default_nettype wire

// ----- src/cyclic_async_buffer_manager.sv -----
// Top level of the cyclical asynchronous buffer manager: configuration registers and sequencer.
// Instantiates cabm_store (free stack, reader counts) and cabm_result (address and output).
// Depends on cabm_pkg, cabm_store and cabm_result.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    operation, buffer_index
//   out      out        out_valid / out_ready  result_index, message_address, status
//
// In the sequencer, the transfer cycle reads the stack and count memories, and the execute state
// that follows decides and writes back through one read-modify-write path.
// In the result stage the product is registered when the execute state hands off, and the base
// add then fills the output register that drives the out channel.
// A stalled result channel holds the sequencer in its execute state once the result stage is full.
// Reset restores the register defaults and the initial pool at once; there is no clearing pass.
// Configuration transfers are taken in every cycle.
`default_nettype none

module cyclic_async_buffer_manager #(
	parameter int NUM_BUFFERS = cabm_pkg::DEF_NUM_BUFFERS,
	parameter int COUNT_WIDTH = cabm_pkg::DEF_COUNT_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [cabm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [cabm_pkg::CFG_W-1:0]         cfg_data,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [cabm_pkg::OP_W-1:0]          operation,
	input  wire [cabm_pkg::IDX_W-1:0]         buffer_index,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [cabm_pkg::IDX_W-1:0]        result_index,
	output logic [cabm_pkg::ADDR_W-1:0]       message_address,
	output logic [cabm_pkg::ST_W-1:0]         status
);
	import cabm_pkg::*;

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int NW = $clog2(NUM_BUFFERS + 1);
	localparam int CW = (NW > BCNT_W) ? NW : BCNT_W;
	localparam int RW = (IW > IDX_W) ? IW : IDX_W;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

	// Configuration registers
	logic [BCNT_W-1:0] buffer_count_q;
	logic [SIZE_W-1:0] message_size_q;
	logic [ADDR_W-1:0] region_base_q;

	// Sequencer and pool state
	logic [0:0]      state_q;
	logic [OP_W-1:0] op_q;
	logic [IDX_W-1:0] idx_q;
	logic [NW-1:0]   free_count_q;
	logic [IW-1:0]   latest_q;

	logic [CW-1:0]   bc_ext;
	logic [CW-1:0]   pool_n;
	logic            accept;
	logic            fire;
	logic            res_start_ready;

	store_ctl_t             st_ctl;
	logic [IW-1:0]          cnt_raddr;
	logic [IW-1:0]          stk_raddr;
	logic [IW-1:0]          cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [IW-1:0]          stk_waddr;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [IW-1:0]          stk_rd;

	logic [IW-1:0]   idx_i;
	logic            idx_ok;
	logic            lat_ok;
	logic            fc_lt_n;
	logic [RW-1:0]   res_w;
	logic [ST_W-1:0] st_w;
	logic            zero_w;
	logic            push_w;
	logic            push_ok;
	logic [IW-1:0]   push_val;
	logic            cnt_we_w;
	logic            fc_dec;
	logic            latest_we;
	logic            init_w;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign fire      = (state_q == S_EXEC) && res_start_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_count_q <= RST_BUFFER_COUNT;
			message_size_q <= RST_MESSAGE_SIZE;
			region_base_q  <= RST_REGION_BASE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BUFFER_COUNT: buffer_count_q <= cfg_data[BCNT_W-1:0];
				REG_MESSAGE_SIZE: message_size_q <= cfg_data[SIZE_W-1:0];
				REG_REGION_BASE:  region_base_q  <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective pool size, clamped to the range the store supports.
	assign bc_ext = CW'(buffer_count_q);
	always_comb begin
		priority if (bc_ext < CW'(2)) begin
			pool_n = CW'(2);
		end else if (bc_ext > CW'(NUM_BUFFERS)) begin
			pool_n = CW'(NUM_BUFFERS);
		end else begin
			pool_n = bc_ext;
		end
	end

	// Reads are issued on the input transfer: counts at the payload index, or at the latest buffer for put and get.
	assign cnt_raddr = (operation == OP_PUT || operation == OP_GET) ? latest_q
		: IW'(buffer_index);
	assign stk_raddr = IW'(free_count_q - NW'(1));

	assign idx_i   = IW'(idx_q);
	assign idx_ok  = CW'(idx_q) < pool_n;
	assign lat_ok  = CW'(latest_q) < pool_n;
	assign fc_lt_n = CW'(free_count_q) < pool_n;

	always_comb begin
		res_w     = RW'(idx_q);
		st_w      = ST_OK;
		zero_w    = 1'b0;
		push_w    = 1'b0;
		push_val  = latest_q;
		cnt_we_w  = 1'b0;
		cnt_wdata = cnt_rd;
		cnt_waddr = idx_i;
		fc_dec    = 1'b0;
		latest_we = 1'b0;
		init_w    = 1'b0;
		unique case (op_q)
			OP_INIT: begin
				init_w = 1'b1;
			end
			OP_RESERVE: begin
				if (free_count_q == '0) begin
					st_w   = ST_NOFREE;
					res_w  = '0;
					zero_w = 1'b1;
				end else begin
					fc_dec = 1'b1;
					res_w  = RW'(stk_rd);
				end
			end
			OP_PUT: begin
				if (!idx_ok) begin
					st_w = ST_BADIDX;
				end else begin
					// The old latest returns to the pool only if no reader still holds it.
					if (lat_ok && latest_q != idx_i && cnt_rd == '0) begin
						push_w   = 1'b1;
						push_val = latest_q;
					end
					latest_we = 1'b1;
				end
			end
			OP_GET: begin
				res_w     = RW'(latest_q);
				cnt_waddr = latest_q;
				if (!lat_ok) begin
					st_w = ST_BADIDX;
				end else if (cnt_rd == CNT_MAX) begin
					st_w = ST_USECNT;
				end else begin
					cnt_we_w  = 1'b1;
					cnt_wdata = cnt_rd + CNT_ONE;
				end
			end
			OP_RELEASE: begin
				if (!idx_ok) begin
					st_w = ST_BADIDX;
				end else if (cnt_rd == '0) begin
					st_w = ST_USECNT;
				end else begin
					cnt_we_w  = 1'b1;
					cnt_wdata = cnt_rd - CNT_ONE;
					if (cnt_rd == CNT_ONE && idx_i != latest_q) begin
						push_w   = 1'b1;
						push_val = idx_i;
					end
				end
			end
			default: begin
				st_w = ST_BADIDX;
			end
		endcase
	end

	// A push onto a full stack is dropped.
	assign push_ok   = push_w && fc_lt_n;
	assign stk_waddr = IW'(free_count_q);

	assign st_ctl.rd_en  = accept;
	assign st_ctl.cnt_we = fire && cnt_we_w;
	assign st_ctl.stk_we = fire && push_ok;
	assign st_ctl.clear  = fire && init_w;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			idx_q <= buffer_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_count_q <= NW'(NUM_BUFFERS - 1);
			latest_q     <= IW'(NUM_BUFFERS - 1);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				priority if (init_w) begin
					free_count_q <= NW'(pool_n - CW'(1));
					latest_q     <= IW'(pool_n - CW'(1));
				end else begin
					if (fc_dec) begin
						free_count_q <= free_count_q - NW'(1);
					end else if (push_ok) begin
						free_count_q <= free_count_q + NW'(1);
					end
					if (latest_we) begin
						latest_q <= idx_i;
					end
				end
			end
		end
	end

	cabm_store #(
		.NUM_BUFFERS (NUM_BUFFERS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (st_ctl),
		.cnt_raddr (cnt_raddr),
		.stk_raddr (stk_raddr),
		.cnt_waddr (cnt_waddr),
		.cnt_wdata (cnt_wdata),
		.stk_waddr (stk_waddr),
		.stk_wdata (push_val),
		.cnt_rdata (cnt_rd),
		.stk_rdata (stk_rd)
	);

	cabm_result #(
		.RW (RW)
	) u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (state_q == S_EXEC),
		.start_ready     (res_start_ready),
		.res_index       (res_w),
		.res_status      (st_w),
		.res_zero        (zero_w),
		.message_size    (message_size_q),
		.region_base     (region_base_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_index    (result_index),
		.message_address (message_address),
		.status          (status)
	);

endmodule

`default_nettype wire

// ----- src/cabm_checker.sv -----
// Port-level checks for the cyclical asynchronous buffer manager, bound to its top level.
// Sees only the top level's ports. Depends on cabm_pkg and cyclic_async_buffer_manager.
`default_nettype none

module cabm_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            cfg_valid,
	input wire                            cfg_ready,
	input wire [cabm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire [cabm_pkg::CFG_W-1:0]      cfg_data,
	input wire                            in_valid,
	input wire                            in_ready,
	input wire [cabm_pkg::OP_W-1:0]       operation,
	input wire [cabm_pkg::IDX_W-1:0]      buffer_index,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire [cabm_pkg::IDX_W-1:0]      result_index,
	input wire [cabm_pkg::ADDR_W-1:0]     message_address,
	input wire [cabm_pkg::ST_W-1:0]       status
);
	import cabm_pkg::*;

	// One operation at a time: a transfer in is always followed by a busy cycle.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after a transfer");

	// An empty free stack answers with buffer zero and a zero address.
	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOFREE |-> result_index == '0 && message_address == '0)
		else $error("no-free result carries a non-zero index or address");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_index)
			&& $stable(message_address) && $stable(status))
		else $error("stalled result changed before its transfer");

	// The configuration port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind cyclic_async_buffer_manager cabm_checker u_cabm_checker (.*);

`default_nettype wire
